[rtl/core/tspp_pkg.sv]
// ----------------------------------------------------------------------------
// Transport stream packet parser package
// Shared constants, result codes and the structs that pass between the
// parser's handshake shell and its per-byte decoder.
// ----------------------------------------------------------------------------
package tspp_pkg;

  localparam int unsigned PacketBytes = 188;
  localparam int unsigned PosW        = 8;
  localparam int unsigned PidW        = 13;
  localparam int unsigned CfgPidW     = 14;
  localparam int unsigned CfgDataW    = 14;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned ClockRefW   = 42;
  localparam int unsigned ShiftW      = 48;
  localparam int unsigned KindW       = 3;
  localparam int unsigned OutDataW    = 64;

  localparam logic [7:0]          SyncByte      = 8'h47;
  localparam logic [PosW-1:0]     PcrFirstPos   = PosW'(6);
  localparam logic [PosW-1:0]     PcrLastPos    = PosW'(11);
  localparam logic [7:0]          PcrMinAdaptLen = 8'd7;
  localparam int unsigned         PcrFlagBit    = 4;
  localparam logic [ClockRefW-1:0] PcrScale     = ClockRefW'(300);
  localparam logic [CfgPidW-1:0]  PidNone       = CfgPidW'(8192);

  typedef enum logic [KindW-1:0] {
    KIND_SYNC_LOSS = 3'd0,
    KIND_VIDEO     = 3'd1,
    KIND_AUDIO     = 3'd2,
    KIND_OTHER     = 3'd3,
    KIND_TABLE     = 3'd4,
    KIND_PCR       = 3'd5
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RUN_ENABLE = 2'd0,
    CFG_PCR_ENABLE = 2'd1,
    CFG_VIDEO_PID  = 2'd2,
    CFG_AUDIO_PID  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               run_enable;
    logic               pcr_enable;
    logic [CfgPidW-1:0] video_pid;
    logic [CfgPidW-1:0] audio_pid;
  } cfg_t;

  typedef struct packed {
    kind_e                kind;
    logic [PidW-1:0]      packet_pid;
    logic [7:0]           payload_byte;
    logic                 unit_start;
    logic                 last_in_packet;
    logic [ClockRefW-1:0] clock_ref;
  } result_t;

endpackage

[rtl/core/tspp_decode.sv]
// ----------------------------------------------------------------------------
// Transport stream packet decoder
// Holds the packet position and header state and turns one stream byte per
// step into at most one result.
// ----------------------------------------------------------------------------
module tspp_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  tspp_pkg::cfg_t   cfg_i,
  output logic             res_valid_o,
  output tspp_pkg::result_t res_o
);

  logic [tspp_pkg::PosW-1:0]   pos_q, pos_d;
  logic [tspp_pkg::PidW-1:0]   pid_q, pid_d;
  logic                        start_q, start_d;
  logic [1:0]                  ctrl_q, ctrl_d;
  logic [7:0]                  len_q, len_d;
  logic [7:0]                  flags_q, flags_d;
  logic [tspp_pkg::ShiftW-1:0] shift_q, shift_d;

  logic [tspp_pkg::ShiftW-1:0]    shift_next;
  logic [tspp_pkg::ClockRefW-1:0] clock_base;
  logic [tspp_pkg::ClockRefW-1:0] pcr_val;
  logic [8:0]                     data_start;
  logic                           has_af;
  logic                           has_pl;
  logic                           pcr_hit;

  assign has_af        = ctrl_q[1];
  assign has_pl        = ctrl_q[0];
  assign shift_next    = {shift_q[tspp_pkg::ShiftW-9:0], byte_i};
  assign clock_base    = tspp_pkg::ClockRefW'(shift_next[tspp_pkg::ShiftW-1:15]);
  assign pcr_val       = tspp_pkg::ClockRefW'(clock_base * tspp_pkg::PcrScale)
                         + tspp_pkg::ClockRefW'(shift_next[8:0]);
  assign data_start    = has_af ? (9'd5 + {1'b0, len_q}) : 9'd4;
  assign pcr_hit       = has_af && (pos_q == tspp_pkg::PcrLastPos) && cfg_i.pcr_enable &&
                         (pid_q != '0) && (len_q >= tspp_pkg::PcrMinAdaptLen) &&
                         flags_q[tspp_pkg::PcrFlagBit];

  always_comb begin
    pos_d       = pos_q;
    pid_d       = pid_q;
    start_d     = start_q;
    ctrl_d      = ctrl_q;
    len_d       = len_q;
    flags_d     = flags_q;
    shift_d     = shift_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = tspp_pkg::KIND_SYNC_LOSS;
    if (step_i) begin
      if ((pos_q == '0) || (pos_q >= tspp_pkg::PosW'(tspp_pkg::PacketBytes))) begin
        if (byte_i != tspp_pkg::SyncByte) begin
          pos_d       = '0;
          res_valid_o = 1'b1;
        end else begin
          pos_d = tspp_pkg::PosW'(1);
        end
      end else begin
        pos_d = (pos_q == tspp_pkg::PosW'(tspp_pkg::PacketBytes - 1)) ? '0 : pos_q + 1'b1;
        if (pos_q == tspp_pkg::PosW'(1)) begin
          start_d = byte_i[6];
          pid_d   = {byte_i[4:0], 8'h00};
        end else if (pos_q == tspp_pkg::PosW'(2)) begin
          pid_d = {pid_q[12:8], byte_i};
        end else if (pos_q == tspp_pkg::PosW'(3)) begin
          ctrl_d  = byte_i[5:4];
          len_d   = '0;
          flags_d = '0;
          shift_d = '0;
        end else if (has_af && (pos_q == tspp_pkg::PosW'(4))) begin
          len_d = byte_i;
        end else begin
          if (has_af && (pos_q == tspp_pkg::PosW'(5)) && (len_q != '0)) begin
            flags_d = byte_i;
          end
          if ((pos_q >= tspp_pkg::PcrFirstPos) && (pos_q <= tspp_pkg::PcrLastPos)) begin
            shift_d = shift_next;
          end
          if (pcr_hit) begin
            if (pcr_val != '0) begin
              res_valid_o      = 1'b1;
              res_o.kind       = tspp_pkg::KIND_PCR;
              res_o.packet_pid = pid_q;
              res_o.unit_start = start_q;
              res_o.clock_ref  = pcr_val;
            end
          end else if (has_pl && ({1'b0, pos_q} >= data_start)) begin
            res_valid_o          = 1'b1;
            res_o.packet_pid     = pid_q;
            res_o.payload_byte   = byte_i;
            res_o.unit_start     = start_q;
            res_o.last_in_packet =
              (pos_q == tspp_pkg::PosW'(tspp_pkg::PacketBytes - 1));
            if (pid_q == '0) begin
              res_o.kind = tspp_pkg::KIND_TABLE;
            end else if (cfg_i.video_pid == {1'b0, pid_q}) begin
              res_o.kind = tspp_pkg::KIND_VIDEO;
            end else if (cfg_i.audio_pid == {1'b0, pid_q}) begin
              res_o.kind = tspp_pkg::KIND_AUDIO;
            end else begin
              res_o.kind = tspp_pkg::KIND_OTHER;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pid_q   <= '0;
      start_q <= 1'b0;
      ctrl_q  <= '0;
      len_q   <= '0;
      flags_q <= '0;
      shift_q <= '0;
    end else begin
      pos_q   <= pos_d;
      pid_q   <= pid_d;
      start_q <= start_d;
      ctrl_q  <= ctrl_d;
      len_q   <= len_d;
      flags_q <= flags_d;
      shift_q <= shift_d;
    end
  end

endmodule

[rtl/core/ts_packet_pcr_parser.sv]
// ----------------------------------------------------------------------------
// Transport stream packet and PCR parser
// Path: a result passes the input register, then the result register; bytes
// that give no result leave nothing. Throughput: one byte per cycle, set by
// the single decode pass per byte, while m_axis_tready does not stall output.
// Reset clears the packet position so the parser waits for a sync byte, and
// loads the register defaults: parsing stopped, PCR reporting on, no PIDs.
// ----------------------------------------------------------------------------
module ts_packet_pcr_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tspp_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tspp_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // stream_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // packet_pid[12:0], payload_byte[20:13], unit_start[21], clock_ref[63:22]
  output logic [tspp_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic [tspp_pkg::KindW-1:0]       m_axis_tuser,  // kind
  output logic                             m_axis_tlast   // last_in_packet
);

  tspp_pkg::cfg_t    cfg_q, cfg_d;
  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_valid_q, out_valid_d;
  tspp_pkg::result_t out_q;
  tspp_pkg::result_t res;
  logic              res_valid;
  logic              advance;
  logic              in_take;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tspp_pkg::cfg_idx_e'(cfg_idx_i))
        tspp_pkg::CFG_RUN_ENABLE: cfg_d.run_enable = cfg_data_i[0];
        tspp_pkg::CFG_PCR_ENABLE: cfg_d.pcr_enable = cfg_data_i[0];
        tspp_pkg::CFG_VIDEO_PID:  cfg_d.video_pid  = cfg_data_i[tspp_pkg::CfgPidW-1:0];
        tspp_pkg::CFG_AUDIO_PID:  cfg_d.audio_pid  = cfg_data_i[tspp_pkg::CfgPidW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign in_take       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  assign in_valid_d  = (s_axis_tvalid && s_axis_tready) ? 1'b1 :
                       (in_take ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? (in_take && res_valid) : out_valid_q;

  tspp_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_take && cfg_q.run_enable),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_enable <= 1'b0;
      cfg_q.pcr_enable <= 1'b1;
      cfg_q.video_pid  <= tspp_pkg::PidNone;
      cfg_q.audio_pid  <= tspp_pkg::PidNone;
      in_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && in_take && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last_in_packet;
  assign m_axis_tdata  = {out_q.clock_ref, out_q.unit_start, out_q.payload_byte,
                          out_q.packet_pid};

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the result register is empty");

  a_sync_loss_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == tspp_pkg::KIND_SYNC_LOSS)) |->
      ((m_axis_tdata == '0) && !m_axis_tlast))
    else $error("sync-loss result carries data");

  a_last_only_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      ((m_axis_tuser == tspp_pkg::KIND_VIDEO) || (m_axis_tuser == tspp_pkg::KIND_AUDIO) ||
       (m_axis_tuser == tspp_pkg::KIND_OTHER) || (m_axis_tuser == tspp_pkg::KIND_TABLE)))
    else $error("last flag on a non-payload result");

  a_clock_ref_only_pcr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != tspp_pkg::KIND_PCR)) |->
      (m_axis_tdata[63:22] == '0))
    else $error("clock reference set on a non-PCR result");

  a_pcr_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == tspp_pkg::KIND_PCR)) |->
      ((m_axis_tdata[63:22] != '0) && (m_axis_tdata[12:0] != '0)))
    else $error("PCR result with zero value or zero PID");

endmodule
